FILE: hw/rtl/scu_pkg.sv
// ----------------------------------------------------------------------------
// scu_pkg: shared types and constants of the scalar colormap unit
// Fixed-point formats, colormap codes and pipeline geometry used by the
// lanes, the merge stage, the divider and the colormap stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scu_pkg;

  // Normalized value: Q0.12 fraction, one extra bit so that exactly one fits
  localparam int FRAC_BITS = 12;
  localparam int FRAC_ONE  = 1 << FRAC_BITS;
  localparam int FRAC_HALF = FRAC_ONE / 2;
  localparam int T_BITS    = FRAC_BITS + 1;

  // Rainbow arithmetic works in units of 1/RB_UNIT
  localparam int RB_UNIT   = 20480;
  localparam int RB_OFFSET = 16384;
  localparam int RB_GAIN   = 22;
  localparam int RB_BITS   = 20;
  localparam int TENT_BITS = 16;
  // RB_UNIT * 2 = 5 * 2^RB_SHIFT
  localparam int RB_SHIFT  = 13;

  // Divide by five: multiply by reciprocal, exact for the quotient range used
  localparam int DIV5_MUL   = 52429;
  localparam int DIV5_SHIFT = 18;
  localparam int DIV5_BITS  = 16;

  // Input geometry
  localparam int INPUT_SAMPLES  = 4;
  localparam int COUNT_BITS     = 3;
  localparam int CFG_INDEX_BITS = 2;

  // Pipeline geometry: lane stage, two merge stages, divider, two colormap stages
  localparam int LANE_STAGE   = 0;
  localparam int MERGE_STAGE  = 1;
  localparam int DIV_STAGE    = 3;
  localparam int CMAP_STAGE   = DIV_STAGE + FRAC_BITS;
  localparam int PIPE_STAGES  = CMAP_STAGE + 2;

  typedef enum logic [1:0] {
    CMAP_GRAY    = 2'd0,
    CMAP_RAINBOW = 2'd1,
    CMAP_GREEN   = 2'd2
  } cmap_mode_t;

  // Saturation class of the normalized value, decided before the divider
  typedef struct packed {
    logic sat_zero;
    logic sat_one;
  } tclass_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scu_lane.sv
// ----------------------------------------------------------------------------
// scu_lane: one sample lane
// Subtracts the range minimum from its sample, or yields zero when the lane
// lies beyond the sample count, and registers the difference.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scu_lane
  import scu_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int LANE        = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [COUNT_BITS-1:0]         count,
  input  logic signed [SAMPLE_BITS-1:0] range_lo,
  output logic signed [SAMPLE_BITS:0]   diff
);

  logic signed [SAMPLE_BITS:0] diff_next;

  // Offset the sample, drop it when the lane is unused
  always_comb begin
    if (COUNT_BITS'(LANE) < count) begin
      diff_next = {sample[SAMPLE_BITS-1], sample} - {range_lo[SAMPLE_BITS-1], range_lo};
    end else begin
      diff_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= diff_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/scu_merge.sv
// ----------------------------------------------------------------------------
// scu_merge: merging stage of the lanes
// Sums the lane differences into the numerator, forms the denominator
// count * (maximum - minimum), then fixes signs and sorts out the saturated
// and degenerate cases before the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scu_merge
  import scu_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_SAMPLES = 4,
  localparam int NW = SAMPLE_BITS + 3,
  localparam int UW = SAMPLE_BITS + 2
) (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic signed [SAMPLE_BITS:0]   lane_diff [MAX_SAMPLES],
  input  logic [COUNT_BITS-1:0]         count,
  input  logic signed [SAMPLE_BITS-1:0] range_lo,
  input  logic signed [SAMPLE_BITS-1:0] range_hi,
  output logic [UW-1:0]                 num,
  output logic [UW-1:0]                 den,
  output tclass_t                       tclass
);

  logic signed [NW-1:0]        sum_next;
  logic signed [NW-1:0]        den_next;
  logic signed [SAMPLE_BITS:0] span;
  logic signed [NW-1:0]        span_ext;
  logic signed [NW-1:0]        count_ext;
  logic signed [NW-1:0]        sum_r;
  logic signed [NW-1:0]        den_r;
  logic                        den_neg;
  logic signed [NW-1:0]        num_fix;
  logic signed [NW-1:0]        den_fix;
  tclass_t                     tclass_next;

  // Add up the lanes and scale the range by the count
  always_comb begin
    sum_next = '0;
    for (int l = 0; l < MAX_SAMPLES; l++) begin
      sum_next = sum_next + {{(NW-SAMPLE_BITS-1){lane_diff[l][SAMPLE_BITS]}}, lane_diff[l]};
    end
    span      = {range_hi[SAMPLE_BITS-1], range_hi} - {range_lo[SAMPLE_BITS-1], range_lo};
    span_ext  = {{(NW-SAMPLE_BITS-1){span[SAMPLE_BITS]}}, span};
    count_ext = {{(NW-COUNT_BITS){1'b0}}, count};
    den_next  = count_ext * span_ext;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sum_r <= sum_next;
      den_r <= den_next;
    end
  end

  // Flip signs for a reversed range and classify on the raw values
  always_comb begin
    den_neg = den_r[NW-1];
    num_fix = den_neg ? -sum_r : sum_r;
    den_fix = den_neg ? -den_r : den_r;
    tclass_next.sat_zero = (den_r == '0) ||
                           (den_neg ? (!sum_r[NW-1])
                                    : (sum_r[NW-1] || (sum_r == '0)));
    tclass_next.sat_one  = !tclass_next.sat_zero &&
                           (den_neg ? (sum_r <= den_r) : (sum_r >= den_r));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num    <= num_fix[UW-1:0];
      den    <= den_fix[UW-1:0];
      tclass <= tclass_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/scu_div.sv
// ----------------------------------------------------------------------------
// scu_div: pipelined restoring divider
// One quotient bit per stage: yields floor(num * 2^FRAC_BITS / den) for
// num < den, and carries the saturation class alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scu_div
  import scu_pkg::*;
#(
  parameter int UW = 18
) (
  input  logic                 clk,
  input  logic [FRAC_BITS-1:0] en,
  input  logic [UW-1:0]        num,
  input  logic [UW-1:0]        den,
  input  tclass_t              tclass_in,
  output logic [FRAC_BITS-1:0] quot,
  output tclass_t              tclass_out
);

  logic [UW-1:0]        rem_q [FRAC_BITS];
  logic [UW-1:0]        den_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_q [FRAC_BITS];
  tclass_t              cls_q [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    logic [UW-1:0]        rem_in;
    logic [UW-1:0]        den_in;
    logic [FRAC_BITS-1:0] quo_in;
    tclass_t              cls_in;
    logic [UW:0]          shifted;
    logic [UW:0]          reduced;
    logic                 take;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign cls_in = tclass_in;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign cls_in = cls_q[k-1];
    end

    // Shift in one bit, subtract the divisor when it fits
    assign shifted = {rem_in, 1'b0};
    assign take    = shifted >= {1'b0, den_in};
    assign reduced = shifted - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_q[k] <= take ? reduced[UW-1:0] : shifted[UW-1:0];
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[FRAC_BITS-2:0], take};
        cls_q[k] <= cls_in;
      end
    end
  end

  assign quot       = quo_q[FRAC_BITS-1];
  assign tclass_out = cls_q[FRAC_BITS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/scu_cmap.sv
// ----------------------------------------------------------------------------
// scu_cmap: colormap stage
// Saturates the normalized value and maps it to RGB. The first stage builds
// the grayscale and green ramp colors and the scaled rainbow channels; the
// second divides the rainbow channels by five and holds the output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scu_cmap
  import scu_pkg::*;
#(
  parameter int COLOR_BITS = 8,
  localparam int QW = COLOR_BITS + 4
) (
  input  logic                  clk,
  input  logic [1:0]            en,
  input  cmap_mode_t            mode,
  input  logic [FRAC_BITS-1:0]  quot,
  input  tclass_t               tclass,
  output logic [COLOR_BITS-1:0] red,
  output logic [COLOR_BITS-1:0] green,
  output logic [COLOR_BITS-1:0] blue
);

  localparam logic signed [RB_BITS-1:0] RB_U1 = RB_BITS'(RB_UNIT);
  localparam logic signed [RB_BITS-1:0] RB_U2 = RB_BITS'(2 * RB_UNIT);
  localparam logic signed [RB_BITS-1:0] RB_U3 = RB_BITS'(3 * RB_UNIT);
  localparam logic signed [RB_BITS-1:0] RB_U4 = RB_BITS'(4 * RB_UNIT);
  localparam logic signed [RB_BITS-1:0] RB_U5 = RB_BITS'(5 * RB_UNIT);

  // Fraction of FRAC_ONE to color, round half up
  function automatic logic [COLOR_BITS-1:0] frac_color(input logic [T_BITS-1:0] x);
    logic [T_BITS+COLOR_BITS-1:0] prod;
    prod = {x, {COLOR_BITS{1'b0}}} - {{COLOR_BITS{1'b0}}, x}
           + (T_BITS+COLOR_BITS)'(FRAC_HALF);
    return prod[FRAC_BITS +: COLOR_BITS];
  endfunction

  // Tent of the rainbow: k*U - |w - a*U| - |w - b*U|, floored at zero
  function automatic logic [TENT_BITS-1:0] tent(input logic signed [RB_BITS-1:0] w,
                                                input logic signed [RB_BITS-1:0] ku,
                                                input logic signed [RB_BITS-1:0] au,
                                                input logic signed [RB_BITS-1:0] bu);
    logic signed [RB_BITS-1:0] da;
    logic signed [RB_BITS-1:0] db;
    logic signed [RB_BITS-1:0] d;
    da = w - au;
    db = w - bu;
    if (da[RB_BITS-1]) da = -da;
    if (db[RB_BITS-1]) db = -db;
    d = ku - da - db;
    return d[RB_BITS-1] ? '0 : d[TENT_BITS-1:0];
  endfunction

  // Tent times full scale plus half of 2U, then drop 2^RB_SHIFT
  function automatic logic [QW-1:0] rb_scale(input logic [TENT_BITS-1:0] dv);
    logic [TENT_BITS+COLOR_BITS:0] n;
    n = {1'b0, dv, {COLOR_BITS{1'b0}}} - {{(COLOR_BITS+1){1'b0}}, dv}
        + (TENT_BITS+COLOR_BITS+1)'(RB_UNIT);
    return n[RB_SHIFT +: QW];
  endfunction

  function automatic logic [COLOR_BITS-1:0] div5(input logic [QW-1:0] q);
    logic [QW+DIV5_BITS-1:0] prod;
    prod = {{DIV5_BITS{1'b0}}, q} * (QW+DIV5_BITS)'(DIV5_MUL);
    return prod[DIV5_SHIFT +: COLOR_BITS];
  endfunction

  logic [T_BITS-1:0]         t_val;
  logic [T_BITS-1:0]         ramp;
  logic signed [RB_BITS-1:0] rb_w;
  logic [COLOR_BITS-1:0]     flat_next [3];
  logic [QW-1:0]             rb_next [3];
  logic [COLOR_BITS-1:0]     flat_r [3];
  logic [QW-1:0]             rb_r [3];

  // Saturate t and build the rainbow channels and the gray or green color
  always_comb begin
    if (tclass.sat_zero) begin
      t_val = '0;
    end else if (tclass.sat_one) begin
      t_val = T_BITS'(FRAC_ONE);
    end else begin
      t_val = {1'b0, quot};
    end

    rb_w = {{(RB_BITS-T_BITS){1'b0}}, t_val} * RB_BITS'(RB_GAIN) + RB_BITS'(RB_OFFSET);
    rb_next[0] = rb_scale(tent(rb_w, RB_U3, RB_U4, RB_U5));
    rb_next[1] = rb_scale(tent(rb_w, RB_U4, RB_U2, RB_U4));
    rb_next[2] = rb_scale(tent(rb_w, RB_U3, RB_U1, RB_U2));

    ramp = '0;
    flat_next[0] = '0;
    flat_next[1] = '0;
    flat_next[2] = '0;
    unique case (mode)
      CMAP_GRAY: begin
        flat_next[0] = frac_color(t_val);
        flat_next[1] = flat_next[0];
        flat_next[2] = flat_next[0];
      end
      CMAP_GREEN: begin
        if (t_val < T_BITS'(FRAC_HALF)) begin
          ramp = {t_val[T_BITS-2:0], 1'b0};
          flat_next[1] = frac_color(ramp);
        end else begin
          ramp = T_BITS'(t_val - T_BITS'(FRAC_HALF)) << 1;
          flat_next[0] = frac_color(ramp);
          flat_next[1] = {COLOR_BITS{1'b1}};
          flat_next[2] = flat_next[0];
        end
      end
      default: begin
        // rainbow is finished in the next stage; the unused code stays black
        flat_next[0] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      flat_r <= flat_next;
      rb_r   <= rb_next;
    end
  end

  // Finish the rainbow channels and hold the output word
  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (mode == CMAP_RAINBOW) begin
        red   <= div5(rb_r[0]);
        green <= div5(rb_r[1]);
        blue  <= div5(rb_r[2]);
      end else begin
        red   <= flat_r[0];
        green <= flat_r[1];
        blue  <= flat_r[2];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/scalar_colormap_unit_top.sv
// ----------------------------------------------------------------------------
// scalar_colormap_unit_top: scalar to RGB colormap unit
// Averages one to four signed samples, normalizes against the configured
// range and maps the value to RGB (grayscale, rainbow or green ramp).
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word: four samples and a
//   count. Output channel (out_valid/out_ready) returns one RGB word per
//   input word, in order. The configuration channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) is always ready and writes colormap_mode (0),
//   range_minimum (1) and range_maximum (2). It is to be written only while
//   idle, a rule for the user that the block does not enforce. A word
//   passes the lane stage, two merge stages, the 12-stage restoring divider
//   and two colormap stages. Throughput: one word per cycle while not stalled.
//   Reset clears the pipeline and loads mode 0, minimum 0 and maximum at
//   the largest positive sample. When the receiver stalls, the output word
//   holds; empty stages behind it keep filling, so the input stalls only
//   once all 17 stages hold words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scalar_colormap_unit_top
  import scu_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COLOR_BITS  = 8,
  parameter int MAX_SAMPLES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_first,
  input  logic signed [SAMPLE_BITS-1:0] sample_second,
  input  logic signed [SAMPLE_BITS-1:0] sample_third,
  input  logic signed [SAMPLE_BITS-1:0] sample_fourth,
  input  logic [COUNT_BITS-1:0]         sample_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COLOR_BITS-1:0]         red,
  output logic [COLOR_BITS-1:0]         green,
  output logic [COLOR_BITS-1:0]         blue,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [SAMPLE_BITS-1:0]        cfg_data
);

  localparam int UW = SAMPLE_BITS + 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX  = 2'd2;
  localparam logic [COUNT_BITS-1:0]     MAX_CNT  = COUNT_BITS'(MAX_SAMPLES);

  cmap_mode_t                    colormap_mode;
  logic signed [SAMPLE_BITS-1:0] range_minimum;
  logic signed [SAMPLE_BITS-1:0] range_maximum;

  logic [PIPE_STAGES-1:0]        stage_vld;
  logic [PIPE_STAGES-1:0]        stage_en;

  logic signed [SAMPLE_BITS-1:0] samples [INPUT_SAMPLES];
  logic [COUNT_BITS-1:0]         count_clamped;
  logic [COUNT_BITS-1:0]         count_l;
  logic signed [SAMPLE_BITS:0]   lane_diff [MAX_SAMPLES];
  logic [UW-1:0]                 merge_num;
  logic [UW-1:0]                 merge_den;
  tclass_t                       merge_cls;
  logic [FRAC_BITS-1:0]          div_quot;
  tclass_t                       div_cls;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      colormap_mode <= CMAP_GRAY;
      range_minimum <= '0;
      range_maximum <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: colormap_mode <= cmap_mode_t'(cfg_data[1:0]);
        REG_MIN:  range_minimum <= cfg_data;
        REG_MAX:  range_maximum <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    stage_en[PIPE_STAGES-1] = !stage_vld[PIPE_STAGES-1] || out_ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      stage_en[i] = !stage_vld[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      if (stage_en[0]) begin
        stage_vld[0] <= in_valid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (stage_en[i]) begin
          stage_vld[i] <= stage_vld[i-1];
        end
      end
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = stage_vld[PIPE_STAGES-1];

  // Clamp the count to one .. MAX_SAMPLES
  always_comb begin
    priority if (sample_count == '0) begin
      count_clamped = COUNT_BITS'(1);
    end else if (sample_count > MAX_CNT) begin
      count_clamped = MAX_CNT;
    end else begin
      count_clamped = sample_count;
    end
  end

  assign samples[0] = sample_first;
  assign samples[1] = sample_second;
  assign samples[2] = sample_third;
  assign samples[3] = sample_fourth;

  always_ff @(posedge clk) begin
    if (stage_en[LANE_STAGE]) begin
      count_l <= count_clamped;
    end
  end

  // Sample lanes
  for (genvar l = 0; l < MAX_SAMPLES; l++) begin : g_lane
    scu_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LANE        (l)
    ) u_lane (
      .clk      (clk),
      .en       (stage_en[LANE_STAGE]),
      .sample   (samples[l]),
      .count    (count_clamped),
      .range_lo (range_minimum),
      .diff     (lane_diff[l])
    );
  end

  scu_merge #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_merge (
    .clk       (clk),
    .en        (stage_en[MERGE_STAGE +: 2]),
    .lane_diff (lane_diff),
    .count     (count_l),
    .range_lo  (range_minimum),
    .range_hi  (range_maximum),
    .num       (merge_num),
    .den       (merge_den),
    .tclass    (merge_cls)
  );

  scu_div #(
    .UW (UW)
  ) u_div (
    .clk        (clk),
    .en         (stage_en[DIV_STAGE +: FRAC_BITS]),
    .num        (merge_num),
    .den        (merge_den),
    .tclass_in  (merge_cls),
    .quot       (div_quot),
    .tclass_out (div_cls)
  );

  scu_cmap #(
    .COLOR_BITS (COLOR_BITS)
  ) u_cmap (
    .clk    (clk),
    .en     (stage_en[CMAP_STAGE +: 2]),
    .mode   (colormap_mode),
    .quot   (div_quot),
    .tclass (div_cls),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/scu_checker.sv
// ----------------------------------------------------------------------------
// scu_checker: port-level checks of the scalar colormap unit
// Watches the top-level handshakes over time; attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scu_checker #(
  parameter int COLOR_BITS = 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COLOR_BITS-1:0] red,
  input logic [COLOR_BITS-1:0] green,
  input logic [COLOR_BITS-1:0] blue,
  input logic                  cfg_ready
);

  // A stalled output word stays valid
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its color
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
    else $error("output color changed while stalled");

  // Reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // With the output free to move, the input never stalls
  assert property (@(posedge clk) (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled although the output can drain");

  // Configuration writes are never held off
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind scalar_colormap_unit_top scu_checker #(
  .COLOR_BITS (COLOR_BITS)
) u_scu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .red       (red),
  .green     (green),
  .blue      (blue),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
